@@ design/ffla_pkg.sv @@
// Shared types and constants for the first-fit lane assigner.
// No dependencies; imported by every module of the block.
package ffla_pkg;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int LANE_W     = 5;
  localparam int MARGIN_W   = 16;
  localparam int FONT_W     = 10;
  localparam int BOTTOM_W   = 12;
  localparam int SPACING_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Fixed spacing added between cue lines
  localparam logic [SPACING_W-1:0] CUE_GAP    = 12'd12;
  localparam logic [MARGIN_W-1:0]  MARGIN_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BILINGUAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_FONT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_FONT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM     = 3'd5;

  // Reset values of the configuration registers
  localparam logic [FONT_W-1:0]   RST_TOLERANCE = 10'd80;
  localparam logic                RST_BILINGUAL = 1'b0;
  localparam logic [FONT_W-1:0]   RST_PRI_FONT  = 10'd48;
  localparam logic [FONT_W-1:0]   RST_SEC_FONT  = 10'd32;
  localparam logic [FONT_W-1:0]   RST_LINE_GAP  = 10'd0;
  localparam logic [BOTTOM_W-1:0] RST_BOTTOM    = 12'd0;

  // Cue travelling down the lane chain
  typedef struct packed {
    logic              active;
    logic              found;
    logic              has_sec;
    logic [TIME_W:0]   start_tol;  // start + tolerance, no wrap
    logic [TIME_W-1:0] end_ms;
  } ffla_token_t;

  // Configuration register bank
  typedef struct packed {
    logic [FONT_W-1:0]   tolerance;
    logic                bilingual;
    logic [FONT_W-1:0]   pri_font;
    logic [FONT_W-1:0]   sec_font;
    logic [FONT_W-1:0]   line_gap;
    logic [BOTTOM_W-1:0] bottom;
  } ffla_cfg_t;

endpackage

@@ design/ffla_cell.sv @@
// One lane of the chain: holds that lane's end time and tests the passing cue.
// Depends on ffla_pkg.
module ffla_cell #(
  parameter int LANES = 16,
  parameter int IDX   = 0,
  localparam int LW   = $clog2(LANES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LW-1:0]        lanes_in_use,
  input  ffla_pkg::ffla_token_t token_in,
  input  logic [LW-1:0]        lane_in,
  output ffla_pkg::ffla_token_t token_out,
  output logic [LW-1:0]        lane_out
);
  import ffla_pkg::*;

  logic [TIME_W-1:0] end_r;
  ffla_token_t       token_r, token_nxt;
  logic [LW-1:0]     lane_r, lane_nxt;
  logic              in_use, fits, opens, claim;

  // Fit test: lane in use and start + tolerance reaches its end time,
  // or this is the next free lane
  always_comb begin
    in_use = lanes_in_use > LW'(IDX);
    fits   = in_use && (token_in.start_tol >= {1'b0, end_r});
    opens  = lanes_in_use == LW'(IDX);
    claim  = token_in.active && !token_in.found && (fits || opens);
    token_nxt       = token_in;
    token_nxt.found = token_in.found | claim;
    lane_nxt        = claim ? LW'(IDX) : lane_in;
  end

  // Hand the cue on to the next lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= '0;
    end else begin
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    if (claim) begin
      end_r <= token_in.end_ms;
    end
  end

  assign token_out = token_r;
  assign lane_out  = lane_r;

endmodule

@@ design/ffla_margin.sv @@
// Margin unit: lane times spacing, then offset, secondary shift and saturation.
// Depends on ffla_pkg; two register stages.
module ffla_margin #(
  parameter int LANES = 16,
  localparam int LW   = $clog2(LANES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffla_pkg::ffla_cfg_t           cfg,
  input  ffla_pkg::ffla_token_t         token,
  input  logic [LW-1:0]                 lane,
  output logic                          out_valid,
  output logic [ffla_pkg::LANE_W-1:0]   out_lane,
  output logic                          out_lane_overflow,
  output logic                          out_secondary_present,
  output logic [ffla_pkg::MARGIN_W-1:0] out_secondary_margin,
  output logic [ffla_pkg::MARGIN_W-1:0] out_primary_margin
);
  import ffla_pkg::*;

  localparam int PW = LW + SPACING_W;   // product
  localparam int BW = PW + 1;           // base
  localparam int SW = BW + 1;           // base plus secondary shift

  logic [FONT_W-1:0]    pri_font, sec_font;
  logic [SPACING_W-1:0] spacing;

  logic          s1_valid_r;
  logic          s1_ovf_r, s1_sec_r;
  logic [LW-1:0] s1_lane_r;
  logic [PW-1:0] s1_prod_r;

  logic [BW-1:0] base;
  logic [SW-1:0] shifted;

  logic                out_valid_r;
  logic [LANE_W-1:0]   out_lane_r;
  logic                out_ovf_r, out_sec_r;
  logic [MARGIN_W-1:0] sec_margin_r, pri_margin_r;
  logic [MARGIN_W-1:0] sec_margin_nxt, pri_margin_nxt;

  // Lane spacing; a zero font size counts as one
  always_comb begin
    pri_font = (cfg.pri_font == '0) ? FONT_W'(1) : cfg.pri_font;
    sec_font = (cfg.sec_font == '0) ? FONT_W'(1) : cfg.sec_font;
    if (cfg.bilingual) begin
      spacing = SPACING_W'(pri_font) + SPACING_W'(sec_font)
              + SPACING_W'(cfg.line_gap) + CUE_GAP;
    end else begin
      spacing = SPACING_W'(pri_font) + CUE_GAP;
    end
  end

  // Stage 1: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= token.active;
    end
  end

  always_ff @(posedge clk) begin
    s1_ovf_r  <= !token.found;
    s1_sec_r  <= cfg.bilingual & token.has_sec;
    s1_lane_r <= lane;
    s1_prod_r <= PW'(lane) * PW'(spacing);
  end

  // Stage 2: offsets and saturation
  always_comb begin
    base    = BW'(cfg.bottom) + BW'(s1_prod_r);
    shifted = SW'(base) + SW'(sec_font) + SW'(cfg.line_gap);
    sec_margin_nxt = '0;
    pri_margin_nxt = '0;
    if (!s1_ovf_r) begin
      if (s1_sec_r) begin
        sec_margin_nxt = (base > BW'(MARGIN_MAX)) ? MARGIN_MAX : base[MARGIN_W-1:0];
        pri_margin_nxt = (shifted > SW'(MARGIN_MAX)) ? MARGIN_MAX : shifted[MARGIN_W-1:0];
      end else begin
        pri_margin_nxt = (base > BW'(MARGIN_MAX)) ? MARGIN_MAX : base[MARGIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_lane_r   <= LANE_W'(s1_lane_r);
    out_ovf_r    <= s1_ovf_r;
    out_sec_r    <= s1_sec_r;
    sec_margin_r <= sec_margin_nxt;
    pri_margin_r <= pri_margin_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_lane              = out_lane_r;
  assign out_lane_overflow     = out_ovf_r;
  assign out_secondary_present = out_sec_r;
  assign out_secondary_margin  = sec_margin_r;
  assign out_primary_margin    = pri_margin_r;

endmodule

@@ design/first_fit_lane_assigner.sv @@
// First-fit lane assigner: a cue walks a chain of LANES cells, one cell a cycle.
// Each result leaves the margin unit after its cue has walked the whole cell chain.
// One cue at a time: busy holds from accept until the result strobe, blocking start.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-low reset: registers take their reset values, no lanes in use.
// Lane end times are written only when a lane opens or is reused.
module first_fit_lane_assigner #(
  parameter int LANES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_start_of_list,
  input  logic [ffla_pkg::TIME_W-1:0]     in_start_ms,
  input  logic [ffla_pkg::TIME_W-1:0]     in_end_ms,
  input  logic                            in_has_secondary_text,
  input  logic                            cfg_we,
  input  logic [ffla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output logic [ffla_pkg::LANE_W-1:0]     out_lane,
  output logic                            out_lane_overflow,
  output logic                            out_secondary_present,
  output logic [ffla_pkg::MARGIN_W-1:0]   out_secondary_margin,
  output logic [ffla_pkg::MARGIN_W-1:0]   out_primary_margin
);
  import ffla_pkg::*;

  localparam int LW = $clog2(LANES + 1);

  ffla_cfg_t     cfg_r;
  logic          busy_r, busy_nxt;
  logic [LW-1:0] lanes_r, lanes_nxt;
  logic          accept;

  ffla_token_t   token [LANES+1];
  logic [LW-1:0] lane  [LANES+1];
  ffla_token_t   head_r, head_nxt;
  logic [LW-1:0] head_lane_r;

  assign accept = start && !busy_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance <= RST_TOLERANCE;
      cfg_r.bilingual <= RST_BILINGUAL;
      cfg_r.pri_font  <= RST_PRI_FONT;
      cfg_r.sec_font  <= RST_SEC_FONT;
      cfg_r.line_gap  <= RST_LINE_GAP;
      cfg_r.bottom    <= RST_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE: cfg_r.tolerance <= cfg_wdata[FONT_W-1:0];
        REG_BILINGUAL: cfg_r.bilingual <= cfg_wdata[0];
        REG_PRI_FONT:  cfg_r.pri_font  <= cfg_wdata[FONT_W-1:0];
        REG_SEC_FONT:  cfg_r.sec_font  <= cfg_wdata[FONT_W-1:0];
        REG_LINE_GAP:  cfg_r.line_gap  <= cfg_wdata[FONT_W-1:0];
        REG_BOTTOM:    cfg_r.bottom    <= cfg_wdata[BOTTOM_W-1:0];
        default:       ;
      endcase
    end
  end

  // Head of chain: cue enters with its tolerance already added
  always_comb begin
    head_nxt.active    = accept;
    head_nxt.found     = 1'b0;
    head_nxt.has_sec   = in_has_secondary_text;
    head_nxt.start_tol = {1'b0, in_start_ms} + (TIME_W+1)'(cfg_r.tolerance);
    head_nxt.end_ms    = in_end_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // A cue that finds no lane comes out of the chain with lane = LANES
  always_ff @(posedge clk) begin
    head_lane_r <= LW'(LANES);
  end

  assign token[0] = head_r;
  assign lane[0]  = head_lane_r;

  // Lane chain
  for (genvar g = 0; g < LANES; g++) begin : g_cell
    ffla_cell #(
      .LANES (LANES),
      .IDX   (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .lanes_in_use (lanes_r),
      .token_in     (token[g]),
      .lane_in      (lane[g]),
      .token_out    (token[g+1]),
      .lane_out     (lane[g+1])
    );
  end

  // Lane count: cleared by start of list, bumped when the tail shows a new lane
  always_comb begin
    lanes_nxt = lanes_r;
    if (accept && in_start_of_list) begin
      lanes_nxt = '0;
    end else if (token[LANES].active && token[LANES].found && lane[LANES] == lanes_r) begin
      lanes_nxt = lanes_r + LW'(1);
    end
  end

  // Busy from accept until the result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (out_valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      lanes_r <= lanes_nxt;
      busy_r  <= busy_nxt;
    end
  end

  ffla_margin #(
    .LANES (LANES)
  ) u_margin (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .token                 (token[LANES]),
    .lane                  (lane[LANES]),
    .out_valid             (out_valid),
    .out_lane              (out_lane),
    .out_lane_overflow     (out_lane_overflow),
    .out_secondary_present (out_secondary_present),
    .out_secondary_margin  (out_secondary_margin),
    .out_primary_margin    (out_primary_margin)
  );

  assign busy = busy_r;

  // Checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result strobe outside a transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result for a transaction");

  a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lanes_r <= LW'(LANES))
    else $error("lane count above LANES");

  a_ovf_margins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lane_overflow) |->
      (out_primary_margin == '0 && out_secondary_margin == '0))
    else $error("margins not cleared on overflow");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for first_fit_lane_assigner: a directed table, then random cue lists.
// It predicts lane choice, overflow and margins, and compares every result transaction.
// Depends on design/ffla_pkg.sv and design/first_fit_lane_assigner.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffla_pkg::*;

  localparam int LANES           = 16;
  localparam int DIRECTED_ROWS   = 24;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 98;
  localparam int QUIET_PHASE     = 4;       // this phase and the next run without gaps
  localparam int CYCLE_LIMIT     = 300000;

  // Indexes beyond the register bank; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    logic              sol;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] end_ms;
    logic              has_sec;
  } cue_t;

  typedef struct packed {
    logic [LANE_W-1:0]   lane;
    logic                overflow;
    logic                sec_present;
    logic [MARGIN_W-1:0] sec_margin;
    logic [MARGIN_W-1:0] pri_margin;
  } placement_t;

  typedef struct packed {
    cue_t       cue;
    logic       typed;   // 1: use the typed placement, else the predictor's
    placement_t want;
  } cue_row_t;

  localparam placement_t NO_CHECK = '0;

  // Directed cues under reset registers: spacing is 48 + 12 = 60 per lane
  localparam cue_row_t CUE_TABLE [DIRECTED_ROWS] = '{
    // fresh list, first cue lands in lane 0
    '{'{1'b1, 32'd1000, 32'd2000, 1'b0}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    // overlaps lane 0 by more than the tolerance: opens lane 1
    '{'{1'b0, 32'd1500, 32'd2500, 1'b0}, 1'b1, '{5'd1, 1'b0, 1'b0, 16'd0, 16'd60}},
    // start + tolerance exactly equals lane 0's end: fits lane 0
    '{'{1'b0, 32'd1920, 32'd3000, 1'b1}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    // fill lanes 2 to 15 with cues that never end
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{1'b0, 32'd100, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    // every lane taken and none fits: overflow, nothing updated
    '{'{1'b0, 32'd100, 32'd5, 1'b1}, 1'b1, '{5'd16, 1'b1, 1'b0, 16'd0, 16'd0}},
    // latest start with reversed end goes back to lane 0
    '{'{1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{'{1'b0, 32'd0, 32'd40, 1'b0}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    // lane end below the tolerance always fits, even at start zero
    '{'{1'b0, 32'd0, 32'd7, 1'b1}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    // new list at the top of the time range
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{'{1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0}, 1'b1, '{5'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{'{1'b0, 32'd0, 32'd123, 1'b0}, 1'b1, '{5'd1, 1'b0, 1'b0, 16'd0, 16'd60}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_start_of_list = 1'b0;
  logic [TIME_W-1:0]     in_start_ms = '0;
  logic [TIME_W-1:0]     in_end_ms = '0;
  logic                  in_has_secondary_text = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  out_valid;
  logic [LANE_W-1:0]     out_lane;
  logic                  out_lane_overflow;
  logic                  out_secondary_present;
  logic [MARGIN_W-1:0]   out_secondary_margin;
  logic [MARGIN_W-1:0]   out_primary_margin;

  first_fit_lane_assigner #(.LANES(LANES)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_start_of_list      (in_start_of_list),
    .in_start_ms           (in_start_ms),
    .in_end_ms             (in_end_ms),
    .in_has_secondary_text (in_has_secondary_text),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_lane              (out_lane),
    .out_lane_overflow     (out_lane_overflow),
    .out_secondary_present (out_secondary_present),
    .out_secondary_margin  (out_secondary_margin),
    .out_primary_margin    (out_primary_margin)
  );

  // Predictor state: register copy, lane end times, lanes open
  ffla_cfg_t         cue_regs;
  logic [TIME_W-1:0] lane_ends [LANES];
  int unsigned       lanes_open;
  logic [TIME_W-1:0] list_clock;
  placement_t        pending_placements [$];

  bit          idling_on;
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned cues_sent;
  int unsigned overflows_seen;
  int unsigned bilingual_seen;
  int unsigned lists_started;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [MARGIN_W-1:0] clip_margin(longint unsigned px);
    return (px > MARGIN_MAX) ? MARGIN_MAX : px[MARGIN_W-1:0];
  endfunction

  // First-fit placement of one cue; updates lane state as the block would
  function automatic placement_t place_cue(cue_t c);
    placement_t      p;
    logic [TIME_W:0] reach;
    int unsigned     slot;
    bit              fits;
    longint unsigned pri_h;
    longint unsigned sec_h;
    longint unsigned spacing;
    longint unsigned base;
    p = '0;
    slot = 0;
    fits = 1'b0;
    if (c.sol) lanes_open = 0;
    // start plus tolerance, kept one bit wider so it never wraps
    reach = {1'b0, c.start_ms} + cue_regs.tolerance;
    while (slot < lanes_open && !fits) begin
      if (reach >= {1'b0, lane_ends[slot]}) fits = 1'b1;
      else slot++;
    end
    p.sec_present = cue_regs.bilingual & c.has_sec;
    if (!fits && lanes_open >= LANES) begin
      p.lane = LANE_W'(lanes_open);
      p.overflow = 1'b1;
      return p;
    end
    lane_ends[slot] = c.end_ms;
    if (!fits) lanes_open++;
    // zero font sizes count as one pixel
    pri_h = (cue_regs.pri_font == '0) ? 1 : cue_regs.pri_font;
    sec_h = (cue_regs.sec_font == '0) ? 1 : cue_regs.sec_font;
    spacing = cue_regs.bilingual ? pri_h + sec_h + cue_regs.line_gap + CUE_GAP
                                 : pri_h + CUE_GAP;
    base = cue_regs.bottom + slot * spacing;
    p.lane = LANE_W'(slot);
    if (p.sec_present) begin
      p.sec_margin = clip_margin(base);
      p.pri_margin = clip_margin(base + sec_h + cue_regs.line_gap);
    end else begin
      p.pri_margin = clip_margin(base);
    end
    return p;
  endfunction

  // Present one cue and hold it until accepted; start stays high on return
  task automatic issue_cue(cue_t c, logic typed, placement_t want);
    placement_t predicted;
    if (idling_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start                 <= 1'b1;
    in_start_of_list      <= c.sol;
    in_start_ms           <= c.start_ms;
    in_end_ms             <= c.end_ms;
    in_has_secondary_text <= c.has_sec;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = place_cue(c);
    pending_placements.insert(pending_placements.size(), typed ? want : predicted);
    cues_sent++;
  endtask

  // Wait for every outstanding result and for the block to go idle
  task automatic drain();
    start <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    // values are cut to register width; unknown indexes are dropped
    case (idx)
      REG_TOLERANCE: cue_regs.tolerance = val[FONT_W-1:0];
      REG_BILINGUAL: cue_regs.bilingual = val[0];
      REG_PRI_FONT:  cue_regs.pri_font  = val[FONT_W-1:0];
      REG_SEC_FONT:  cue_regs.sec_font  = val[FONT_W-1:0];
      REG_LINE_GAP:  cue_regs.line_gap  = val[FONT_W-1:0];
      REG_BOTTOM:    cue_regs.bottom    = val[BOTTOM_W-1:0];
      default: ;
    endcase
  endtask

  // Register setting per phase: all-ones, all-zero, reset values, then random
  task automatic set_registers(int phase);
    logic [CFG_DATA_W-1:0] v [6];
    for (int i = 0; i < 6; i++) begin
      case (phase)
        0:       v[i] = '1;
        1:       v[i] = '0;
        default: v[i] = CFG_DATA_W'($urandom_range(0, 4095));
      endcase
    end
    if (phase == 2) begin
      v[0] = RST_TOLERANCE;
      v[1] = RST_BILINGUAL;
      v[2] = RST_PRI_FONT;
      v[3] = RST_SEC_FONT;
      v[4] = RST_LINE_GAP;
      v[5] = RST_BOTTOM;
    end
    write_reg(REG_TOLERANCE, v[0]);
    write_reg(REG_BILINGUAL, v[1]);
    write_reg(REG_PRI_FONT, v[2]);
    write_reg(REG_SEC_FONT, v[3]);
    write_reg(REG_LINE_GAP, v[4]);
    write_reg(REG_BOTTOM, v[5]);
    write_reg(REG_UNUSED_A, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_UNUSED_B, CFG_DATA_W'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ordered cue lists with bursts that pile up lanes; some noise
  task automatic make_cue(output cue_t c);
    int unsigned pick;
    pick = $urandom_range(99);
    c.sol = 1'b0;
    c.has_sec = 1'($urandom_range(1));
    if (pick < 4) begin
      c.sol = 1'b1;
      lists_started++;
      case ($urandom_range(2))
        0:       list_clock = '0;
        1:       list_clock = $urandom_range(0, 2000);
        default: list_clock = $urandom;
      endcase
      c.start_ms = list_clock;
      c.end_ms   = list_clock + $urandom_range(0, 4000);
    end else if (pick < 12) begin
      c.start_ms = $urandom;
      c.end_ms   = $urandom;
    end else if (pick < 22) begin
      c.start_ms = list_clock;
      c.end_ms   = list_clock + $urandom_range(2000, 20000);
    end else begin
      list_clock = list_clock + $urandom_range(0, 400);
      c.start_ms = list_clock;
      if ($urandom_range(19) == 0) c.end_ms = list_clock - $urandom_range(0, 500);
      else c.end_ms = list_clock + $urandom_range(0, 4000);
    end
  endtask

  // Result checking against the oldest outstanding placement
  always @(posedge clk) begin : result_check
    placement_t want;
    if (rst_n && out_valid) begin
      if (pending_placements.size() == 0) begin
        $error("result transaction with no cue outstanding: lane %0d", out_lane);
        failures++;
      end else begin
        want = pending_placements.pop_front();
        if (out_lane !== want.lane) begin
          $error("lane: expected %0d, got %0d", want.lane, out_lane);
          failures++;
        end
        if (out_lane_overflow !== want.overflow) begin
          $error("lane_overflow: expected %0d, got %0d", want.overflow, out_lane_overflow);
          failures++;
        end
        if (out_secondary_present !== want.sec_present) begin
          $error("secondary_present: expected %0d, got %0d",
                 want.sec_present, out_secondary_present);
          failures++;
        end
        if (out_secondary_margin !== want.sec_margin) begin
          $error("secondary_margin: expected %0d, got %0d",
                 want.sec_margin, out_secondary_margin);
          failures++;
        end
        if (out_primary_margin !== want.pri_margin) begin
          $error("primary_margin: expected %0d, got %0d", want.pri_margin, out_primary_margin);
          failures++;
        end
        if (want.overflow) overflows_seen++;
        if (want.sec_present) bilingual_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    cue_t c;
    cue_regs.tolerance = RST_TOLERANCE;
    cue_regs.bilingual = RST_BILINGUAL;
    cue_regs.pri_font  = RST_PRI_FONT;
    cue_regs.sec_font  = RST_SEC_FONT;
    cue_regs.line_gap  = RST_LINE_GAP;
    cue_regs.bottom    = RST_BOTTOM;
    lanes_open = 0;
    list_clock = '0;
    idling_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_cue(CUE_TABLE[i].cue, CUE_TABLE[i].typed, CUE_TABLE[i].want);
    drain();

    // random cue lists, one register setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      set_registers(phase);
      idling_on = !(phase == QUIET_PHASE || phase == QUIET_PHASE + 1);
      repeat (ITEMS_PER_PHASE) begin
        make_cue(c);
        issue_cue(c, 1'b0, NO_CHECK);
      end
      drain();
    end

    // catch any stray result after the last one
    repeat (LANES + 5) @(posedge clk);
    if (pending_placements.size() != 0) begin
      $error("%0d placements never arrived", pending_placements.size());
      failures++;
    end
    $display("Placed %0d cues over %0d register settings and %0d random list restarts.",
             cues_sent, PHASES + 1, lists_started);
    $display("Lane overflows seen: %0d, results with a secondary line: %0d.",
             overflows_seen, bilingual_seen);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ffla_pkg.sv
design/ffla_cell.sv
design/ffla_margin.sv
design/first_fit_lane_assigner.sv
verif/tb_top.sv
